@@ rtl/core/valve_pump_safety_interlock_top_macros.svh @@
// Assertion macros shared by the interlock RTL.
`ifndef VALVE_PUMP_SAFETY_INTERLOCK_TOP_MACROS_SVH
`define VALVE_PUMP_SAFETY_INTERLOCK_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock, off while in reset.
`define VPSI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("interlock check failed");
// Next-cycle implication.
`define VPSI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("interlock check failed");
`else
`define VPSI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define VPSI_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/vpsi_pkg.sv @@
// Types, codes and constants of the valve and pump safety interlock.
`timescale 1ns / 1ps
package vpsi_pkg;

  // Slot layout: four groups of three relays, two groups per expander byte
  localparam int SLOTS        = 12;
  localparam int GROUP_STRIDE = 3;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int CNT_W        = $clog2(SLOTS + 1);

  // Link must stay up this long before the loss timer disarms
  localparam int unsigned STABLE_MS = 5000;
  localparam logic [7:0]  IDLE_BYTE = 8'hFF;

  // Port widths
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_W      = 32;
  localparam int CFG_ADDR_W = 2;

  // Parameter defaults
  localparam int DEF_BOX_COUNT   = 4;
  localparam int DEF_VALVES_EACH = 3;
  localparam int DEF_TIME_BITS   = 32;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_VALVE_MAX_ON = 32'd3600000;
  localparam logic [CFG_W-1:0] RST_PUMP_TIMEOUT = 32'd1800000;
  localparam logic [CFG_W-1:0] RST_LINK_SAFETY  = 32'd300000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_VALVE = 2'd1,
    OP_PUMP  = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_IGNORED = 3'd1,
    ST_REFUSED = 3'd2,
    ST_LINK    = 3'd3,
    ST_CAP     = 3'd4,
    ST_PUMP    = 3'd5
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_VALVE_MAX_ON = 2'd0,
    CFG_PUMP_TIMEOUT = 2'd1,
    CFG_LINK_SAFETY  = 2'd2,
    CFG_ACTIVE_LOW   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH,
    S_DONE
  } state_e;

  // Slots that map onto a fitted valve
  function automatic logic [SLOTS-1:0] slot_mask(input int box_count, input int valves_each);
    logic [SLOTS-1:0] m;
    m = '0;
    for (int s = 0; s < SLOTS; s++) begin
      m[s] = ((s / GROUP_STRIDE) < box_count) && ((s % GROUP_STRIDE) < valves_each);
    end
    return m;
  endfunction

endpackage

@@ rtl/core/vpsi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vpsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/valve_pump_safety_interlock_top.sv @@
// Valve and pump safety interlock: command and tick processing, guards, relay images.
//
// Input words (s_axis) carry a command in tuser: a millisecond tick with the link-up
// bit, a set-valve, a set-pump or a stop-all. Every word gives exactly one result word
// on m_axis with both expander relay bytes, the pump drive level, the open, latch and
// capped masks and a status code.
// A command updates the state, then the result is loaded into the output register. A tick
// walks the open-time stamps, which live in a memory with registered read data: the cap
// guard reads one valve per cycle and checks each stamp once its read data is back, then
// the cap-stop and pump timeout checks run, and then the result is loaded.
// One word is processed at a time; the next is taken as soon as the previous result
// sits in the output register, even if the receiver has not yet taken it. If the
// receiver stalls, the finished result waits until the output register frees up.
// Reset closes every valve, clears latches, stops the pump, zeroes the clock and link
// timers and loads the register defaults; the stamp memory needs no clearing pass.
// Registers must be written via cfg_* only while idle; the block does not check this.
`timescale 1ns / 1ps
`include "valve_pump_safety_interlock_top_macros.svh"
module valve_pump_safety_interlock_top #(
  parameter int BOX_COUNT   = vpsi_pkg::DEF_BOX_COUNT,
  parameter int VALVES_EACH = vpsi_pkg::DEF_VALVES_EACH,
  parameter int TIME_BITS   = vpsi_pkg::DEF_TIME_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // box[2:0], valve[5:3], on[6], link_up[7]
  input  logic [vpsi_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // op[1:0]
  input  logic [vpsi_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // expander_low[7:0], expander_high[15:8], pump_drive[16], open_mask[28:17],
  // latch_mask[40:29], capped_mask[52:41], status[55:53]
  output logic [vpsi_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                            cfg_we_i,
  input  logic [vpsi_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [vpsi_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int SLOTS  = vpsi_pkg::SLOTS;
  localparam int SLOT_W = vpsi_pkg::SLOT_W;
  localparam int CNT_W  = vpsi_pkg::CNT_W;
  localparam int CMP_W  = (TIME_BITS > vpsi_pkg::CFG_W) ? TIME_BITS : vpsi_pkg::CFG_W;
  localparam logic [SLOTS-1:0] USED = vpsi_pkg::slot_mask(BOX_COUNT, VALVES_EACH);
  localparam logic [2:0] BOX_MAX   = 3'(BOX_COUNT);
  localparam logic [2:0] VALVE_MAX = 3'(VALVES_EACH);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOTS);
  localparam logic [TIME_BITS-1:0] STABLE_T = TIME_BITS'(vpsi_pkg::STABLE_MS);

  // Configuration registers
  logic [vpsi_pkg::CFG_W-1:0] valve_max_q, pump_timeout_q, link_safety_q;
  logic                       active_low_q;

  // Control and scalar state
  vpsi_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SLOTS-1:0]  open_q, open_d, latch_q, latch_d, capped_q, capped_d;
  logic              pump_q, pump_d, pump_exp_q, pump_exp_d;
  logic [TIME_BITS-1:0] clock_q, clock_d, last_act_q, last_act_d;
  logic              was_up_q, was_up_d, lost_armed_q, lost_armed_d;
  logic              stable_armed_q, stable_armed_d;
  logic [TIME_BITS-1:0] lost_at_q, lost_at_d, stable_at_q, stable_at_d;
  vpsi_pkg::status_e status_q, status_d;
  logic              out_valid_q, out_valid_d;
  logic [vpsi_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  // Stamp memory ports
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_raddr;
  logic [TIME_BITS-1:0] ram_rdata;

  // Input word fields
  vpsi_pkg::op_e in_op;
  logic [2:0]    in_box, in_valve;
  logic          in_on, in_link_up;

  assign in_op      = vpsi_pkg::op_e'(s_axis_tuser_i);
  assign in_box     = s_axis_tdata_i[2:0];
  assign in_valve   = s_axis_tdata_i[5:3];
  assign in_on      = s_axis_tdata_i[6];
  assign in_link_up = s_axis_tdata_i[7];

  // Valve address decode
  logic              addr_ok;
  logic [1:0]        box_m1, valve_m1;
  logic [SLOT_W-1:0] slot;

  assign addr_ok  = (in_box >= 3'd1) && (in_box <= BOX_MAX) &&
                    (in_valve >= 3'd1) && (in_valve <= VALVE_MAX);
  assign box_m1   = 2'(in_box - 3'd1);
  assign valve_m1 = 2'(in_valve - 3'd1);
  assign slot     = SLOT_W'(box_m1) * SLOT_W'(vpsi_pkg::GROUP_STRIDE) + SLOT_W'(valve_m1);

  // Guard comparisons, one subtract and compare each
  logic [TIME_BITS-1:0] clock_n, lost_ref;
  logic [TIME_BITS-1:0] since_act, since_lost, since_stable, since_open;
  logic any_open, active, lost_expired, stable_done, pump_expired, cap_expired;

  assign clock_n      = clock_q + TIME_BITS'(1);
  assign lost_ref     = lost_armed_q ? lost_at_q : clock_n;
  assign since_act    = clock_n - last_act_q;
  assign since_lost   = clock_n - lost_ref;
  assign since_stable = clock_n - stable_at_q;
  assign since_open   = clock_q - ram_rdata;
  assign any_open     = |(open_q & USED);
  assign active       = pump_q || any_open;
  assign lost_expired = CMP_W'(since_lost) >= CMP_W'(link_safety_q);
  assign stable_done  = since_stable >= STABLE_T;
  assign pump_expired = CMP_W'(since_act) >= CMP_W'(pump_timeout_q);
  assign cap_expired  = CMP_W'(since_open) >= CMP_W'(valve_max_q);

  // Result image
  logic [SLOTS-1:0] open_m, latch_m;
  logic [7:0]       bits_lo, bits_hi, exp_lo, exp_hi;
  logic             pump_drive;

  assign open_m     = open_q & USED;
  assign latch_m    = latch_q & USED;
  assign bits_lo    = {2'b00, open_m[5:0]};
  assign bits_hi    = {2'b00, open_m[11:6]};
  assign exp_lo     = active_low_q ? (~bits_lo & vpsi_pkg::IDLE_BYTE) : bits_lo;
  assign exp_hi     = active_low_q ? (~bits_hi & vpsi_pkg::IDLE_BYTE) : bits_hi;
  assign pump_drive = active_low_q ? ~pump_q : pump_q;

  // Open-time stamps, one entry per slot
  vpsi_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (SLOTS)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (clock_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state and datapath
  always_comb begin
    logic [SLOT_W-1:0] chk;
    logic              pump_left;
    chk            = SLOT_W'(cnt_q - CNT_W'(1));
    pump_left      = pump_q;
    state_d        = state_q;
    cnt_d          = cnt_q;
    open_d         = open_q;
    latch_d        = latch_q;
    capped_d       = capped_q;
    pump_d         = pump_q;
    pump_exp_d     = pump_exp_q;
    clock_d        = clock_q;
    last_act_d     = last_act_q;
    was_up_d       = was_up_q;
    lost_armed_d   = lost_armed_q;
    stable_armed_d = stable_armed_q;
    lost_at_d      = lost_at_q;
    stable_at_d    = stable_at_q;
    status_d       = status_q;
    out_valid_d    = out_valid_q && !m_axis_tready_i;
    out_data_d     = out_data_q;
    ram_we         = 1'b0;
    ram_raddr      = cnt_q[SLOT_W-1:0];
    s_axis_tready_o = 1'b0;

    case (state_q)
      vpsi_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          status_d = vpsi_pkg::ST_OK;
          capped_d = '0;
          cnt_d    = '0;
          state_d  = vpsi_pkg::S_DONE;
          case (in_op)
            vpsi_pkg::OP_TICK: begin
              clock_d    = clock_n;
              pump_exp_d = pump_expired;
              state_d    = vpsi_pkg::S_WALK;
              if (in_link_up) begin
                if (!was_up_q) begin
                  was_up_d       = 1'b1;
                  stable_armed_d = 1'b1;
                  stable_at_d    = clock_n;
                end
                // a freshly armed stability timer has seen no time yet
                if (was_up_q && stable_armed_q && stable_done) begin
                  lost_armed_d = 1'b0;
                end
              end else begin
                if (was_up_q) begin
                  was_up_d       = 1'b0;
                  stable_armed_d = 1'b0;
                end
                if (!lost_armed_q) begin
                  lost_armed_d = 1'b1;
                  lost_at_d    = clock_n;
                end
                if (active && lost_expired) begin
                  open_d    = '0;
                  latch_d   = '0;
                  pump_d    = 1'b0;
                  lost_at_d = clock_n;
                  status_d  = vpsi_pkg::ST_LINK;
                end
              end
            end
            vpsi_pkg::OP_VALVE: begin
              if (!addr_ok) begin
                status_d = vpsi_pkg::ST_IGNORED;
              end else if (in_on && latch_q[slot]) begin
                status_d = vpsi_pkg::ST_REFUSED;
              end else begin
                if (!in_on) begin
                  latch_d[slot] = 1'b0;
                end
                // stamp only on the closed-to-open edge
                if (in_on && !open_q[slot]) begin
                  ram_we = 1'b1;
                end
                open_d[slot] = in_on;
                if (in_on) begin
                  last_act_d = clock_q;
                end
              end
            end
            vpsi_pkg::OP_PUMP: begin
              pump_d = in_on;
              if (in_on) begin
                last_act_d = clock_q;
              end
            end
            vpsi_pkg::OP_STOP: begin
              open_d  = '0;
              latch_d = '0;
              pump_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end

      // Cap guard: read slot cnt, check slot cnt-1 against its stamp
      vpsi_pkg::S_WALK: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q != '0) begin
          if (open_q[chk] && USED[chk] && cap_expired) begin
            open_d[chk]   = 1'b0;
            latch_d[chk]  = 1'b1;
            capped_d[chk] = 1'b1;
          end
        end
        if (cnt_q == CNT_END) begin
          state_d = vpsi_pkg::S_FINISH;
        end
      end

      // Cap stop of the pump, then pump inactivity timeout
      vpsi_pkg::S_FINISH: begin
        if (capped_q != '0) begin
          status_d = vpsi_pkg::ST_CAP;
          if (!any_open) begin
            pump_left = 1'b0;
          end
        end
        pump_d = pump_left;
        if (pump_left && pump_exp_q) begin
          open_d   = '0;
          latch_d  = '0;
          pump_d   = 1'b0;
          status_d = vpsi_pkg::ST_PUMP;
        end
        state_d = vpsi_pkg::S_DONE;
      end

      // Load the result word once the output register is free
      vpsi_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {status_q, capped_q, latch_m, open_m, pump_drive, exp_hi, exp_lo};
          state_d     = vpsi_pkg::S_IDLE;
        end
      end

      default: state_d = vpsi_pkg::S_IDLE;
    endcase
  end

  // Sequencer and interlock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= vpsi_pkg::S_IDLE;
      cnt_q          <= '0;
      open_q         <= '0;
      latch_q        <= '0;
      pump_q         <= 1'b0;
      clock_q        <= '0;
      last_act_q     <= '0;
      was_up_q       <= 1'b0;
      lost_armed_q   <= 1'b0;
      stable_armed_q <= 1'b0;
      lost_at_q      <= '0;
      stable_at_q    <= '0;
      out_valid_q    <= 1'b0;
      capped_q       <= '0;
      status_q       <= vpsi_pkg::ST_OK;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      open_q         <= open_d;
      latch_q        <= latch_d;
      pump_q         <= pump_d;
      clock_q        <= clock_d;
      last_act_q     <= last_act_d;
      was_up_q       <= was_up_d;
      lost_armed_q   <= lost_armed_d;
      stable_armed_q <= stable_armed_d;
      lost_at_q      <= lost_at_d;
      stable_at_q    <= stable_at_d;
      out_valid_q    <= out_valid_d;
      capped_q       <= capped_d;
      status_q       <= status_d;
    end
  end

  // Per-word scratch and result payload
  always_ff @(posedge clk_i) begin
    pump_exp_q <= pump_exp_d;
    out_data_q <= out_data_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valve_max_q    <= vpsi_pkg::RST_VALVE_MAX_ON;
      pump_timeout_q <= vpsi_pkg::RST_PUMP_TIMEOUT;
      link_safety_q  <= vpsi_pkg::RST_LINK_SAFETY;
      active_low_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (vpsi_pkg::cfg_idx_e'(cfg_addr_i))
        vpsi_pkg::CFG_VALVE_MAX_ON: valve_max_q    <= cfg_wdata_i;
        vpsi_pkg::CFG_PUMP_TIMEOUT: pump_timeout_q <= cfg_wdata_i;
        vpsi_pkg::CFG_LINK_SAFETY:  link_safety_q  <= cfg_wdata_i;
        vpsi_pkg::CFG_ACTIVE_LOW:   active_low_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // A latched valve is never open
  `VPSI_ASSERT_IMP(a_open_latch_excl, clk_i, rst_ni, 1'b1, (open_q & latch_q) == '0)
  // Absent valves never open or latch
  `VPSI_ASSERT_IMP(a_unused_idle, clk_i, rst_ni, 1'b1, ((open_q | latch_q) & ~USED) == '0)
  // Once the walk is over, a capped valve shows up only with a cap or pump stop status
  `VPSI_ASSERT_IMP(a_capped_status, clk_i, rst_ni,
    capped_q != '0 && (state_q == vpsi_pkg::S_DONE || state_q == vpsi_pkg::S_IDLE),
    status_q == vpsi_pkg::ST_CAP || status_q == vpsi_pkg::ST_PUMP)
  // A finished word reaches the output once the register is free
  `VPSI_ASSERT_NXT(a_done_loads, clk_i, rst_ni,
    state_q == vpsi_pkg::S_DONE && (!out_valid_q || m_axis_tready_i), out_valid_q)

endmodule

@@ verif/tb_top.sv @@
// Self-checking bench for the valve and pump safety interlock: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_top;
  import vpsi_pkg::*;

  localparam int unsigned HOLD_AT        = 150;   // results seen before the long receiver stall
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned PHASE_WORDS    = 310;

  // Result word, laid out as on m_axis_tdata (top field first)
  typedef struct packed {
    status_e     status;
    logic [11:0] capped_m;
    logic [11:0] latch_m;
    logic [11:0] open_m;
    logic        pump_drv;
    logic [7:0]  exp_hi;
    logic [7:0]  exp_lo;
  } relay_word_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    op_e         op;
    logic [2:0]  box;
    logic [2:0]  valve;
    logic        on;
    logic        up;
    int unsigned reps;
    bit          typed;
    relay_word_t want;
    cfg_idx_e    reg_idx;
    logic [31:0] reg_val;
  } plan_row_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [IN_USER_W-1:0]  s_tuser   = '0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  valve_pump_safety_interlock_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  // Interlock state as the bench sees it
  logic [31:0] cap_ms    = RST_VALVE_MAX_ON;
  logic [31:0] pump_ms   = RST_PUMP_TIMEOUT;
  logic [31:0] link_ms   = RST_LINK_SAFETY;
  logic        act_low   = 1'b1;
  logic [31:0] now_ms    = '0;
  logic [11:0] open_bits  = '0;
  logic [11:0] latch_bits = '0;
  logic [31:0] open_stamp [SLOTS];
  logic        pump_on      = 1'b0;
  logic [31:0] last_on_ms   = '0;
  logic        link_seen_up = 1'b0;
  logic        loss_armed   = 1'b0;
  logic [31:0] loss_at      = '0;
  logic        stable_armed = 1'b0;
  logic [31:0] stable_at    = '0;

  relay_word_t awaited_words [$];
  plan_row_t   plan [$];
  int unsigned mismatch_count = 0;
  int unsigned words_seen     = 0;
  int unsigned tx_idle_pct    = 28;
  int unsigned rx_idle_pct    = 56;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  int unsigned quiet_cycles   = 0;

  function automatic void close_everything();
    open_bits  = '0;
    latch_bits = '0;
    pump_on    = 1'b0;
  endfunction

  // Predict the result of one word and advance the interlock state
  function automatic relay_word_t interlock_step(op_e op, logic [2:0] box, logic [2:0] valve,
                                                 logic on, logic up);
    relay_word_t w;
    logic [11:0] capped;
    status_e     st;
    int          slot;
    capped = '0;
    st     = ST_OK;
    case (op)
      OP_TICK: begin
        now_ms = now_ms + 32'd1;
        // link guard
        if (up) begin
          if (!link_seen_up) begin
            link_seen_up = 1'b1;
            stable_armed = 1'b1;
            stable_at    = now_ms;
          end
          if (stable_armed && (now_ms - stable_at) >= STABLE_MS) loss_armed = 1'b0;
        end else begin
          if (link_seen_up) begin
            link_seen_up = 1'b0;
            stable_armed = 1'b0;
          end
          if (!loss_armed) begin
            loss_armed = 1'b1;
            loss_at    = now_ms;
          end
          if ((pump_on || open_bits != '0) && (now_ms - loss_at) >= link_ms) begin
            close_everything();
            loss_at = now_ms;
            st      = ST_LINK;
          end
        end
        // open-time cap
        for (int s = 0; s < SLOTS; s++) begin
          if (open_bits[s] && (now_ms - open_stamp[s]) >= cap_ms) begin
            open_bits[s]  = 1'b0;
            latch_bits[s] = 1'b1;
            capped[s]     = 1'b1;
          end
        end
        if (capped != '0) begin
          st = ST_CAP;
          if (pump_on && open_bits == '0) pump_on = 1'b0;
        end
        // pump inactivity timeout overrides the cap status
        if (pump_on && (now_ms - last_on_ms) >= pump_ms) begin
          close_everything();
          st = ST_PUMP;
        end
      end
      OP_VALVE: begin
        if (box < 3'd1 || box > 3'd4 || valve < 3'd1 || valve > 3'd3) begin
          st = ST_IGNORED;
        end else begin
          slot = (int'(box) - 1) * GROUP_STRIDE + (int'(valve) - 1);
          if (on && latch_bits[slot]) begin
            st = ST_REFUSED;
          end else begin
            if (!on) latch_bits[slot] = 1'b0;
            if (on && !open_bits[slot]) open_stamp[slot] = now_ms;
            open_bits[slot] = on;
            if (on) last_on_ms = now_ms;
          end
        end
      end
      OP_PUMP: begin
        pump_on = on;
        if (on) last_on_ms = now_ms;
      end
      default: close_everything();
    endcase
    w.status   = st;
    w.capped_m = capped;
    w.latch_m  = latch_bits;
    w.open_m   = open_bits;
    w.pump_drv = act_low ? ~pump_on : pump_on;
    w.exp_lo   = {2'b00, open_bits[5:0]};
    w.exp_hi   = {2'b00, open_bits[11:6]};
    if (act_low) begin
      w.exp_lo = ~w.exp_lo;
      w.exp_hi = ~w.exp_hi;
    end
    return w;
  endfunction

  // Everything closed, relays active low: read straight off the spec
  function automatic relay_word_t idle_word(status_e st, logic [11:0] latch);
    relay_word_t w;
    w          = '0;
    w.status   = st;
    w.latch_m  = latch;
    w.pump_drv = 1'b1;
    w.exp_lo   = 8'hFF;
    w.exp_hi   = 8'hFF;
    return w;
  endfunction

  function automatic void plan_word(op_e op, logic [2:0] box, logic [2:0] valve, logic on,
                                    logic up, int unsigned reps, bit typed, relay_word_t want);
    plan_row_t r;
    r.kind  = ROW_WORD;
    r.op    = op;
    r.box   = box;
    r.valve = valve;
    r.on    = on;
    r.up    = up;
    r.reps  = reps;
    r.typed = typed;
    r.want  = want;
    plan.push_back(r);
  endfunction

  function automatic void plan_reg(cfg_idx_e idx, logic [31:0] val);
    plan_row_t r;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    plan.push_back(r);
  endfunction

  function automatic void check_word(relay_word_t want, relay_word_t got);
    if (got.exp_lo !== want.exp_lo) begin
      $display("%0t: expander_low expected %h got %h", $time, want.exp_lo, got.exp_lo);
      mismatch_count++;
    end
    if (got.exp_hi !== want.exp_hi) begin
      $display("%0t: expander_high expected %h got %h", $time, want.exp_hi, got.exp_hi);
      mismatch_count++;
    end
    if (got.pump_drv !== want.pump_drv) begin
      $display("%0t: pump_drive expected %b got %b", $time, want.pump_drv, got.pump_drv);
      mismatch_count++;
    end
    if (got.open_m !== want.open_m) begin
      $display("%0t: open_mask expected %h got %h", $time, want.open_m, got.open_m);
      mismatch_count++;
    end
    if (got.latch_m !== want.latch_m) begin
      $display("%0t: latch_mask expected %h got %h", $time, want.latch_m, got.latch_m);
      mismatch_count++;
    end
    if (got.capped_m !== want.capped_m) begin
      $display("%0t: capped_mask expected %h got %h", $time, want.capped_m, got.capped_m);
      mismatch_count++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
      mismatch_count++;
    end
  endfunction

  // Offer one word; returns just after the edge that took it
  task automatic send_word(op_e op, logic [2:0] box, logic [2:0] valve, logic on, logic up,
                           bit typed, relay_word_t want);
    relay_word_t model_w;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {up, on, valve, box};
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    model_w = interlock_step(op, box, valve, on, up);
    awaited_words.push_back(typed ? want : model_w);
  endtask

  // Stop offering and wait until every result is back, so the block is idle
  task automatic settle();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_VALVE_MAX_ON: cap_ms  = val;
      CFG_PUMP_TIMEOUT: pump_ms = val;
      CFG_LINK_SAFETY:  link_ms = val;
      default:          act_low = val[0];
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Random traffic built from bursts: tick runs, valve commands, pump commands, stop-all commands, noise
  task automatic random_traffic(int unsigned n);
    int unsigned counted;
    int unsigned pick;
    int unsigned run_len;
    logic        up;
    logic [2:0]  b;
    logic [2:0]  v;
    op_e         op;
    counted = 0;
    while (counted < n) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        run_len = $urandom_range(30, 1);
        up      = ($urandom_range(99) < 80);
        repeat (run_len) begin
          send_word(OP_TICK, 3'($urandom), 3'($urandom), 1'($urandom), up, 1'b0, '0);
          counted++;
        end
      end else if (pick < 75) begin
        repeat ($urandom_range(4, 1)) begin
          send_word(OP_VALVE, 3'($urandom_range(4, 1)), 3'($urandom_range(3, 1)),
                    ($urandom_range(99) < 70), 1'($urandom), 1'b0, '0);
          counted++;
        end
      end else if (pick < 87) begin
        send_word(OP_PUMP, 3'($urandom), 3'($urandom), ($urandom_range(99) < 75),
                  1'($urandom), 1'b0, '0);
        counted++;
      end else if (pick < 90) begin
        send_word(OP_STOP, 3'($urandom), 3'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
        counted++;
      end else begin
        op = op_e'($urandom_range(3));
        b  = 3'($urandom);
        v  = 3'($urandom);
        send_word(op, b, v, 1'($urandom), 1'($urandom), 1'b0, '0);
        // ignored valve addresses do not count
        if (!(op == OP_VALVE && (b < 3'd1 || b > 3'd4 || v < 3'd1 || v > 3'd3))) counted++;
      end
    end
  endtask

  task automatic run_phase(logic [31:0] cap, logic [31:0] pump, logic [31:0] link, logic low,
                           int unsigned tx_pct, int unsigned rx_pct);
    settle();
    write_reg(CFG_VALVE_MAX_ON, cap);
    write_reg(CFG_PUMP_TIMEOUT, pump);
    write_reg(CFG_LINK_SAFETY, link);
    write_reg(CFG_ACTIVE_LOW, {31'd0, low});
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    random_traffic(PHASE_WORDS);
  endtask

  // Receiver: random stalls, plus one long hold-off so the block backs up
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && words_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      words_seen++;
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        check_word(awaited_words.pop_front(), relay_word_t'(m_axis_tdata_o));
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    foreach (open_stamp[s]) open_stamp[s] = '0;

    // Directed table: reset state, bad addresses, cap, refusal, link and pump stops, stop-all, active-high cap
    plan_word(OP_TICK,  3'd7, 3'd7, 1'b1, 1'b0, 1, 1'b1, idle_word(ST_OK, '0));
    plan_word(OP_VALVE, 3'd0, 3'd1, 1'b1, 1'b1, 1, 1'b1, idle_word(ST_IGNORED, '0));
    plan_word(OP_VALVE, 3'd5, 3'd2, 1'b0, 1'b0, 1, 1'b1, idle_word(ST_IGNORED, '0));
    plan_word(OP_VALVE, 3'd2, 3'd0, 1'b1, 1'b1, 1, 1'b1, idle_word(ST_IGNORED, '0));
    plan_word(OP_VALVE, 3'd7, 3'd7, 1'b1, 1'b0, 1, 1'b1, idle_word(ST_IGNORED, '0));
    plan_reg(CFG_VALVE_MAX_ON, 32'd3);
    plan_reg(CFG_PUMP_TIMEOUT, 32'd6);
    plan_reg(CFG_LINK_SAFETY, 32'd2);
    plan_word(OP_VALVE, 3'd1, 3'd1, 1'b1, 1'b0, 1, 1'b0, '0);
    plan_word(OP_VALVE, 3'd4, 3'd3, 1'b1, 1'b1, 1, 1'b0, '0);
    plan_word(OP_PUMP,  3'd6, 3'd5, 1'b1, 1'b1, 1, 1'b0, '0);
    // cap closes both valves on the third tick, the pump follows
    plan_word(OP_TICK,  3'd0, 3'd0, 1'b0, 1'b1, 3, 1'b0, '0);
    plan_word(OP_VALVE, 3'd1, 3'd1, 1'b1, 1'b0, 1, 1'b1, idle_word(ST_REFUSED, 12'h801));
    plan_word(OP_VALVE, 3'd1, 3'd1, 1'b0, 1'b1, 1, 1'b0, '0);
    // link drops with the pump running and the loss timer long since armed
    plan_word(OP_PUMP,  3'd0, 3'd0, 1'b1, 1'b0, 1, 1'b0, '0);
    plan_word(OP_TICK,  3'd0, 3'd0, 1'b0, 1'b0, 2, 1'b0, '0);
    // pump alone until it times out
    plan_word(OP_PUMP,  3'd3, 3'd4, 1'b1, 1'b0, 1, 1'b0, '0);
    plan_word(OP_TICK,  3'd0, 3'd0, 1'b1, 1'b1, 7, 1'b0, '0);
    plan_word(OP_VALVE, 3'd3, 3'd2, 1'b1, 1'b0, 1, 1'b0, '0);
    plan_word(OP_STOP,  3'd4, 3'd4, 1'b1, 1'b1, 1, 1'b1, idle_word(ST_OK, '0));
    plan_reg(CFG_ACTIVE_LOW, 32'd0);
    plan_word(OP_VALVE, 3'd2, 3'd3, 1'b1, 1'b1, 1, 1'b0, '0);
    // a run of up ticks caps the open valve with active-high relays
    plan_word(OP_TICK,  3'd1, 3'd6, 1'b0, 1'b1, 40, 1'b0, '0);
    plan_word(OP_VALVE, 3'd2, 3'd3, 1'b0, 1'b0, 1, 1'b0, '0);
    plan_word(OP_VALVE, 3'd1, 3'd2, 1'b1, 1'b1, 1, 1'b0, '0);
    plan_word(OP_TICK,  3'd0, 3'd0, 1'b0, 1'b0, 3, 1'b0, '0);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        repeat (plan[i].reps)
          send_word(plan[i].op, plan[i].box, plan[i].valve, plan[i].on, plan[i].up,
                    plan[i].typed, plan[i].want);
      end
    end

    // Random phases: sender-light idling, then receiver-light, then none
    run_phase(32'd20, 32'd30, 32'd10, 1'b1, 28, 56);
    run_phase(32'd1, 32'd1, 32'd1, 1'b0, 28, 56);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 56, 28);
    run_phase($urandom_range(60, 2), $urandom_range(120, 5), $urandom_range(40, 2),
              1'($urandom), 56, 28);
    run_phase(32'd50, 32'd15, 32'd25, 1'b0, 0, 0);
    run_phase($urandom_range(60, 2), $urandom_range(120, 5), $urandom_range(40, 2),
              1'($urandom), 0, 0);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_words.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ valve_pump_safety_interlock_top.f @@
+incdir+rtl/core
rtl/core/vpsi_pkg.sv
rtl/core/vpsi_ram.sv
rtl/core/valve_pump_safety_interlock_top.sv
verif/tb_top.sv
